FILE: hdl/ssbck_pkg.sv
// Shared types and constants of the scaled sprite blit with color key.
// Used by the divider pipeline and the top level; depends on nothing.
`default_nettype none

package ssbck_pkg;

   // command codes
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPRITE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEST_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_X         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_Y         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COLOR     = 3'd6;

   // field widths
   localparam int SPR_DIM_W  = 13;
   localparam int DEST_DIM_W = 10;
   localparam int POS_W      = 11;
   localparam int COLOR_W    = 16;
   localparam int INDEX_W    = 12;
   localparam int FB_ADDR_W  = 18;

   // scaling divider: (offset * sprite size) / dest size
   localparam int DIVIDEND_W     = DEST_DIM_W + SPR_DIM_W;
   localparam int DEN_W          = DEST_DIM_W;
   localparam int QUO_W          = SPR_DIM_W;
   localparam int DIV_STEPS      = 2;
   localparam int DIV_STAGES     = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

   typedef struct packed {
      logic                  cmd;
      logic [INDEX_W-1:0]    pixel_index;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [DEST_DIM_W-1:0] dx;
      logic [DEST_DIM_W-1:0] dy;
   } req_type;

   typedef struct packed {
      logic                 fb_write;
      logic [FB_ADDR_W-1:0] fb_address;
      logic [COLOR_W-1:0]   pixel_color;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/scaled_sprite_blit_color_key_unit.sv
// Top level of the scaled sprite blit with transparent color key.
// Depends on ssbck_pkg and ssbck_div.
`default_nettype none

// Sprite blitter, one word per clock. A load word (cmd = load) converts an
// RGB888 pixel to RGB565 and writes it to the on-chip sprite store; it gives
// no response. A draw word names one destination pixel (dx, dy) of the scaled
// sprite and always gives exactly one response word: the framebuffer write
// flag, the address row*SCREEN_W + col and the RGB565 color (address and
// color are zero when the write is suppressed). The write is suppressed for
// an offset outside dest_width/dest_height, a source pixel outside the
// sprite or the store, a pixel equal to key_color, or a destination off the
// screen. Draws and loads share one pipeline and issue one word per clock
// with no bubbles; a draw's response passes through the two pipelined
// scaling dividers (two quotient bits per stage) followed by the source
// index multiply, the index add, the store read and the response register.
// Loads write the store at the same stage where draws read it, so every
// draw sees exactly the loads accepted before it; no forwarding is needed.
// The store has no reset and no clearing pass: a pixel must be loaded
// before it is drawn. Configuration registers are to be written through
// the csr port only while no word is in flight; the block itself does not
// enforce this. csr_ready is always high. The pipeline stalls as a whole
// only while a response waits on rsp_ready.
module scaled_sprite_blit_color_key_unit
   import ssbck_pkg::*;
#(
   parameter int STORE_DEPTH = 4096,
   parameter int SCREEN_W    = 480,
   parameter int SCREEN_H    = 320
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request words
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_data,
   // response words
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_data,
   // configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW      = $clog2(STORE_DEPTH);
   localparam int SRC_W   = 2 * SPR_DIM_W + 1;
   localparam int LIDX_W  = (AW > INDEX_W) ? AW + 1 : INDEX_W + 1;
   localparam int SW_W    = $clog2(SCREEN_W + 1);
   localparam int FB_W    = DEST_DIM_W + SW_W + 1;
   localparam int COORD_W = POS_W + 1;

   // per-word sideband that rides along the divider pipeline
   typedef struct packed {
      logic                 is_draw;
      logic                 load_ok;
      logic [INDEX_W-1:0]   load_idx;
      logic [COLOR_W-1:0]   load_color;
      logic                 reject;     // dest miss or off screen
      logic [FB_ADDR_W-1:0] fb_addr;
   } side_type;

   // ---------------- configuration registers ----------------
   logic [SPR_DIM_W-1:0]  sprite_width_ff, sprite_height_ff;
   logic [DEST_DIM_W-1:0] dest_width_ff, dest_height_ff;
   logic [POS_W-1:0]      pos_x_ff, pos_y_ff;
   logic [COLOR_W-1:0]    key_color_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_width_ff  <= SPR_DIM_W'(64);
         sprite_height_ff <= SPR_DIM_W'(64);
         dest_width_ff    <= DEST_DIM_W'(64);
         dest_height_ff   <= DEST_DIM_W'(64);
         pos_x_ff         <= '0;
         pos_y_ff         <= '0;
         key_color_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_data[SPR_DIM_W-1:0];
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_data[SPR_DIM_W-1:0];
            CSR_DEST_WIDTH:    dest_width_ff    <= csr_data[DEST_DIM_W-1:0];
            CSR_DEST_HEIGHT:   dest_height_ff   <= csr_data[DEST_DIM_W-1:0];
            CSR_POS_X:         pos_x_ff         <= csr_data[POS_W-1:0];
            CSR_POS_Y:         pos_y_ff         <= csr_data[POS_W-1:0];
            CSR_KEY_COLOR:     key_color_ff     <= csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves when the response register is free or drains
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------- accept stage ----------------
   logic signed [COORD_W-1:0] col_s, row_s;
   logic                      on_screen, dest_miss;
   side_type                  side_acc;

   always_comb begin
      col_s = $signed({pos_x_ff[POS_W-1], pos_x_ff}) +
              $signed({{(COORD_W-DEST_DIM_W){1'b0}}, req_data.dx});
      row_s = $signed({pos_y_ff[POS_W-1], pos_y_ff}) +
              $signed({{(COORD_W-DEST_DIM_W){1'b0}}, req_data.dy});
      on_screen = !col_s[COORD_W-1] && (col_s[COORD_W-2:0] < (COORD_W-1)'(SCREEN_W)) &&
                  !row_s[COORD_W-1] && (row_s[COORD_W-2:0] < (COORD_W-1)'(SCREEN_H));
      dest_miss = (req_data.dx >= dest_width_ff) || (req_data.dy >= dest_height_ff);

      side_acc.is_draw    = (req_data.cmd == CMD_DRAW);
      side_acc.load_ok    = LIDX_W'(req_data.pixel_index) < LIDX_W'(STORE_DEPTH);
      side_acc.load_idx   = req_data.pixel_index;
      // RGB888 -> RGB565
      side_acc.load_color = {req_data.red[7:3], req_data.green[7:2], req_data.blue[7:3]};
      side_acc.reject     = dest_miss || !on_screen;
      side_acc.fb_addr    = '0;
   end

   // P1: scaling products and screen coordinates
   logic                   p1_valid_ff;
   side_type               p1_side_ff;
   logic [DEST_DIM_W-1:0]  p1_col_ff, p1_row_ff;
   logic [DIVIDEND_W-1:0]  p1_prod_x_ff, p1_prod_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_side_ff   <= side_acc;
         // only meaningful when on screen, where they fit DEST_DIM_W bits
         p1_col_ff    <= col_s[DEST_DIM_W-1:0];
         p1_row_ff    <= row_s[DEST_DIM_W-1:0];
         p1_prod_x_ff <= DIVIDEND_W'(req_data.dx) * DIVIDEND_W'(sprite_width_ff);
         p1_prod_y_ff <= DIVIDEND_W'(req_data.dy) * DIVIDEND_W'(sprite_height_ff);
      end
   end

   // ---------------- scaling dividers ----------------
   logic [QUO_W-1:0] src_x, src_y;

   ssbck_div u_div_x (
      .clock    (clock),
      .enable   (advance),
      .dividend (p1_prod_x_ff),
      .divisor  (dest_width_ff),
      .quotient (src_x)
   );

   ssbck_div u_div_y (
      .clock    (clock),
      .enable   (advance),
      .dividend (p1_prod_y_ff),
      .divisor  (dest_height_ff),
      .quotient (src_y)
   );

   // sideband delay line matching the divider; framebuffer address is
   // formed on entry
   logic     dl_valid_ff [DIV_STAGES];
   side_type dl_side_ff  [DIV_STAGES];
   side_type dl_side_in;
   logic [FB_W-1:0] fb_full;

   always_comb begin
      fb_full = FB_W'(p1_row_ff) * FB_W'(SCREEN_W) + FB_W'(p1_col_ff);
      dl_side_in = p1_side_ff;
      dl_side_in.fb_addr = FB_ADDR_W'(fb_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            dl_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         dl_valid_ff[0] <= p1_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dl_valid_ff[i] <= dl_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dl_side_ff[0] <= dl_side_in;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dl_side_ff[i] <= dl_side_ff[i-1];
         end
      end
   end

   // ---------------- stage A: row offset multiply ----------------
   logic                    a_valid_ff, a_bad_ff;
   side_type                a_side_ff;
   logic [QUO_W-1:0]        a_src_x_ff;
   logic [2*SPR_DIM_W-1:0]  a_row_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= dl_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff    <= dl_side_ff[DIV_STAGES-1];
         a_src_x_ff   <= src_x;
         a_bad_ff     <= (src_x >= sprite_width_ff) || (src_y >= sprite_height_ff);
         a_row_off_ff <= (2*SPR_DIM_W)'(src_y) * (2*SPR_DIM_W)'(sprite_width_ff);
      end
   end

   // ---------------- stage B: source index ----------------
   logic            b_valid_ff, b_src_ok_ff;
   side_type        b_side_ff;
   logic [AW-1:0]   b_addr_ff;
   logic [SRC_W-1:0] src_sum;

   assign src_sum = SRC_W'(a_row_off_ff) + SRC_W'(a_src_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_side_ff   <= a_side_ff;
         b_src_ok_ff <= !a_bad_ff && (src_sum < SRC_W'(STORE_DEPTH));
         b_addr_ff   <= src_sum[AW-1:0];
      end
   end

   // ---------------- stage C: sprite store access ----------------
   // loads write and draws read at this one stage, in arrival order
   logic [COLOR_W-1:0] sprite_store [STORE_DEPTH];
   logic               c_valid_ff, c_src_ok_ff;
   side_type           c_side_ff;
   logic [COLOR_W-1:0] c_rdata_ff;

   always_ff @(posedge clock) begin
      if (advance && b_valid_ff) begin
         if (!b_side_ff.is_draw && b_side_ff.load_ok) begin
            sprite_store[AW'(b_side_ff.load_idx)] <= b_side_ff.load_color;
         end
         c_rdata_ff <= sprite_store[b_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_side_ff   <= b_side_ff;
         c_src_ok_ff <= b_src_ok_ff;
      end
   end

   // ---------------- response register ----------------
   rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      if (c_src_ok_ff && !c_side_ff.reject && (c_rdata_ff != key_color_ff)) begin
         rsp_data_in.fb_write    = 1'b1;
         rsp_data_in.fb_address  = c_side_ff.fb_addr;
         rsp_data_in.pixel_color = c_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid_ff && c_side_ff.is_draw;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/ssbck_div.sv
// Pipelined restoring divider for the nearest-neighbor source coordinate.
// Needs ssbck_pkg for widths and stage count; advances only when enabled.
`default_nettype none

module ssbck_div
   import ssbck_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  enable,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DEN_W-1:0]      divisor,
   output logic      [QUO_W-1:0]      quotient
);

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
   } div_state_type;

   div_state_type stage_ff [DIV_STAGES];
   div_state_type stage_in [DIV_STAGES];

   // quotient is known to fit QUO_W bits when the offset is inside the
   // destination, so the top dividend bits start as the partial remainder
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         div_state_type   cur;
         logic [DEN_W:0]  trial;
         if (s == 0) begin
            cur.rem = dividend[DIVIDEND_W-1:QUO_W];
            cur.num = dividend[QUO_W-1:0];
            cur.quo = '0;
         end else begin
            cur = stage_ff[(s == 0) ? 0 : s-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            if (s * DIV_STEPS + k < QUO_W) begin
               trial = {cur.rem, cur.num[QUO_W-1]};
               cur.num = {cur.num[QUO_W-2:0], 1'b0};
               if (trial >= {1'b0, divisor}) begin
                  cur.rem = DEN_W'(trial - {1'b0, divisor});
                  cur.quo = {cur.quo[QUO_W-2:0], 1'b1};
               end else begin
                  cur.rem = trial[DEN_W-1:0];
                  cur.quo = {cur.quo[QUO_W-2:0], 1'b0};
               end
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign quotient = stage_ff[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for scaled_sprite_blit_color_key_unit: a directed table, then random phases.
// Depends on ssbck_pkg and the block's RTL; responses are compared with a blit model or table.

module tb;
   import ssbck_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int STORE_DEPTH  = 4096;
   localparam int SCREEN_W     = 480;
   localparam int SCREEN_H     = 320;
   // drain wait, sized from DIV_STAGES to outlast the whole pipeline
   localparam int DRAIN_CYCLES = 2 * (DIV_STAGES + 4);
   localparam int HOLD_CYCLES  = 80;
   localparam int IDLE_PCT     = 17;
   localparam int MAX_REPORTS  = 10;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 110;
   localparam int STEADY_PHASE = 5;
   localparam int HOLD_PHASE   = 6;
   localparam int PAUSE_PHASE  = 7;
   localparam int NUM_DIRECTED = 31;
   localparam int NUM_CSR      = int'(CSR_KEY_COLOR) + 1;
   localparam int LIMIT_CYCLES = 400_000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam rsp_type NO_WRITE = '0;

   // one row of the directed table: either a csr write or a request word
   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
      req_type                word;
      logic                   typed;   // want holds a hand-written response
      rsp_type                want;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // local copy of the block's registers and sprite store
   logic [SPR_DIM_W-1:0]        spr_w = 64;
   logic [SPR_DIM_W-1:0]        spr_h = 64;
   logic [DEST_DIM_W-1:0]       dst_w = 64;
   logic [DEST_DIM_W-1:0]       dst_h = 64;
   logic signed [POS_W-1:0]     org_x = '0;
   logic signed [POS_W-1:0]     org_y = '0;
   logic [COLOR_W-1:0]          key   = '0;
   logic [COLOR_W-1:0]          sprite_mem [STORE_DEPTH];
   bit                          loaded     [STORE_DEPTH];

   rsp_type pending_blits[$];   // responses still owed by the block, oldest first
   int      fault_count   = 0;
   int      hold_requests = 0;  // bumped by stimulus, served by the response side
   bit      steady        = 1'b0;

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   scaled_sprite_blit_color_key_unit #(
      .STORE_DEPTH(STORE_DEPTH),
      .SCREEN_W   (SCREEN_W),
      .SCREEN_H   (SCREEN_H)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // ---------------------------------------------------------------------
   // Blit model
   // ---------------------------------------------------------------------

   // Nearest-neighbor source lookup. Returns 1 only when the draw actually
   // reads the store; src is then the row-major store index.
   function automatic bit source_of(input logic [DEST_DIM_W-1:0] dx,
                                    input logic [DEST_DIM_W-1:0] dy,
                                    output int unsigned src);
      int unsigned    sx, sy;
      longint unsigned lin;
      src = 0;
      // also catches a zero destination size, before any divide
      if (dx >= dst_w || dy >= dst_h) return 1'b0;
      sx = (int'(dx) * int'(spr_w)) / int'(dst_w);
      sy = (int'(dy) * int'(spr_h)) / int'(dst_h);
      // zero sprite size lands here
      if (sx >= spr_w || sy >= spr_h) return 1'b0;
      lin = longint'(sy) * longint'(spr_w) + longint'(sx);
      if (lin >= STORE_DEPTH) return 1'b0;
      src = int'(lin);
      return 1'b1;
   endfunction

   // Applies one accepted word to the local state. Returns 1 when the word
   // owes a response (every draw), with that response in r.
   function automatic bit blit_pixel(input req_type w, output rsp_type r);
      int unsigned src;
      int          col, row;
      r = NO_WRITE;
      if (w.cmd == CMD_LOAD) begin
         // RGB888 -> RGB565, the low bits of each byte are dropped
         if (w.pixel_index < STORE_DEPTH) begin
            sprite_mem[w.pixel_index] = {w.red[7:3], w.green[7:2], w.blue[7:3]};
            loaded[w.pixel_index]     = 1'b1;
         end
         return 1'b0;
      end
      if (!source_of(w.dx, w.dy, src)) return 1'b1;
      if (sprite_mem[src] == key) return 1'b1;   // transparent
      col = int'(org_x) + int'(w.dx);
      row = int'(org_y) + int'(w.dy);
      if (col < 0 || col >= SCREEN_W || row < 0 || row >= SCREEN_H) return 1'b1;
      r.fb_write    = 1'b1;
      r.fb_address  = FB_ADDR_W'(row * SCREEN_W + col);
      r.pixel_color = sprite_mem[src];
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Table rows and random words
   // ---------------------------------------------------------------------

   function automatic rsp_type hit(input int unsigned addr, input logic [COLOR_W-1:0] color);
      rsp_type r;
      r.fb_write    = 1'b1;
      r.fb_address  = FB_ADDR_W'(addr);
      r.pixel_color = color;
      return r;
   endfunction

   function automatic step_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                        input logic [CSR_DATA_W-1:0] val);
      step_type s;
      s         = '0;
      s.is_csr  = 1'b1;
      s.csr_idx = idx;
      s.csr_val = val;
      return s;
   endfunction

   function automatic step_type load_row(input int unsigned idx,
                                         input logic [7:0] r, g, b);
      step_type s;
      s                  = '0;
      s.word.cmd         = CMD_LOAD;
      s.word.pixel_index = INDEX_W'(idx);
      s.word.red         = r;
      s.word.green       = g;
      s.word.blue        = b;
      return s;
   endfunction

   function automatic step_type draw_row(input int unsigned dx, dy,
                                         input bit typed, input rsp_type want);
      step_type s;
      s          = '0;
      s.word.cmd = CMD_DRAW;
      s.word.dx  = DEST_DIM_W'(dx);
      s.word.dy  = DEST_DIM_W'(dy);
      s.typed    = typed;
      s.want     = want;
      return s;
   endfunction

   // random load; a quarter of them carry bytes that map onto the key color
   function automatic req_type load_word(input int unsigned idx);
      logic [63:0] noise;
      req_type     w;
      noise         = {$urandom, $urandom};
      w             = noise[$bits(req_type)-1:0];
      w.cmd         = CMD_LOAD;
      w.pixel_index = INDEX_W'(idx);
      if ($urandom_range(3) == 0) begin
         w.red   = {key[15:11], 3'($urandom)};
         w.green = {key[10:5],  2'($urandom)};
         w.blue  = {key[4:0],   3'($urandom)};
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Request and csr drivers
   // ---------------------------------------------------------------------

   // Offers one word, holds it until accepted, then updates the model.
   // Idle gaps go in front, so valid stays up between back-to-back words.
   task automatic send_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type r;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      if (blit_pixel(w, r)) pending_blits.push_back(typed ? want : r);
   endtask

   // Registers change only with the block idle: no response owed and
   // enough cycles for trailing loads to leave the pipeline.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_valid <= 1'b0;
      wait (pending_blits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SPRITE_WIDTH:  spr_w = val[SPR_DIM_W-1:0];
         CSR_SPRITE_HEIGHT: spr_h = val[SPR_DIM_W-1:0];
         CSR_DEST_WIDTH:    dst_w = val[DEST_DIM_W-1:0];
         CSR_DEST_HEIGHT:   dst_h = val[DEST_DIM_W-1:0];
         CSR_POS_X:         org_x = val[POS_W-1:0];
         CSR_POS_Y:         org_y = val[POS_W-1:0];
         CSR_KEY_COLOR:     key   = val;
         default: ;         // unknown index, no effect
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, plus a long hold-off on request
   // so the pipeline fills and req_ready drops.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_requests != served) begin
            served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic note_fault(input string msg);
      if (fault_count < MAX_REPORTS) $display("%0t: %s", $time, msg);
      fault_count++;
   endtask

   // Response checker: every accepted response word against the oldest
   // expectation, field by field.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_blits.size() == 0) begin
            note_fault($sformatf("unexpected response: write=%0d addr=%0d color=%h",
                                 rsp_data.fb_write, rsp_data.fb_address,
                                 rsp_data.pixel_color));
         end else begin
            want = pending_blits.pop_front();
            if (rsp_data.fb_write !== want.fb_write ||
                rsp_data.fb_address !== want.fb_address ||
                rsp_data.pixel_color !== want.pixel_color) begin
               note_fault($sformatf({"response mismatch: got write=%0d addr=%0d color=%h, ",
                                     "expected write=%0d addr=%0d color=%h"},
                                    rsp_data.fb_write, rsp_data.fb_address,
                                    rsp_data.pixel_color, want.fb_write,
                                    want.fb_address, want.pixel_color));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      step_type              plan [NUM_DIRECTED];
      logic [CSR_DATA_W-1:0] cfg  [NUM_CSR];
      logic [63:0]           noise;
      req_type               w;
      int unsigned           src, span, idx;
      int                    sw, sh, dw, dh, px, py, kc;

      // Directed words, all under the reset geometry (64x64 onto 64x64 at 0,0)
      // unless a csr row changes it. Stored colors: 0 -> white, 63 -> red,
      // 4032 -> cyan-ish 07FF, 4095 -> black (equal to the reset key).
      plan = '{
         load_row(0,    8'hFF, 8'hFF, 8'hFF),
         load_row(4095, 8'h07, 8'h03, 8'h07),   // low bits dropped -> 0000
         load_row(63,   8'hF8, 8'h00, 8'h00),
         load_row(4032, 8'h07, 8'hFF, 8'hF8),
         draw_row(0,    0,    1, hit(0, 16'hFFFF)),
         draw_row(63,   63,   1, NO_WRITE),           // black equals key
         draw_row(63,   0,    1, hit(63, 16'hF800)),
         draw_row(0,    63,   1, hit(63 * SCREEN_W, 16'h07FF)),
         draw_row(64,   0,    1, NO_WRITE),           // dx past dest width
         draw_row(0,    64,   1, NO_WRITE),           // dy past dest height
         draw_row(1023, 1023, 1, NO_WRITE),
         csr_row(CSR_KEY_COLOR, 16'hF800),
         draw_row(63,   0,    1, NO_WRITE),           // red now transparent
         draw_row(63,   63,   1, hit(63 * SCREEN_W + 63, 16'h0000)),
         csr_row(CSR_POS_X, 16'h03FF),
         csr_row(CSR_POS_Y, 16'hFC00),
         draw_row(0,    0,    1, NO_WRITE),           // off screen
         csr_row(CSR_POS_X, 16'd416),
         csr_row(CSR_POS_Y, 16'd256),
         draw_row(63,   63,   1, hit(153599, 16'h0000)),  // last screen pixel
         draw_row(0,    0,    0, NO_WRITE),
         csr_row(CSR_SPRITE_WIDTH, 16'd0),
         draw_row(0,    0,    1, NO_WRITE),           // zero sprite width
         csr_row(CSR_SPRITE_WIDTH, 16'd4096),
         draw_row(63,   1,    1, NO_WRITE),           // source past the store
         csr_row(CSR_DEST_WIDTH, 16'd0),
         draw_row(0,    0,    1, NO_WRITE),           // zero dest width
         csr_row(CSR_UNUSED, 16'hFFFF),               // must not touch the key
         csr_row(CSR_DEST_WIDTH, 16'd64),
         csr_row(CSR_SPRITE_WIDTH, 16'd64),
         draw_row(63,   63,   0, NO_WRITE)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (plan[i].is_csr) write_csr(plan[i].csr_idx, plan[i].csr_val);
         else send_word(plan[i].word, plan[i].typed, plan[i].want);
      end

      // Random phases, each under its own geometry. Phases 1..3 sit on the
      // register extremes; the rest use small sizes so most draws hit pixels.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         kc = $urandom_range(16'hFFFF);
         case (ph)
            1: begin
               sw = 4096; sh = 1; dw = 1023; dh = 1;
               px = -512; py = $urandom_range(SCREEN_H - 1); kc = 16'hFFFF;
            end
            2: begin
               sw = 1; sh = 4096; dw = 1; dh = 1023;
               px = SCREEN_W - 1; py = -700; kc = 0;
            end
            3: begin
               sw = 4096; sh = 4096; dw = 1023; dh = 1023;
               px = -1024; py = 1023;
            end
            default: begin
               sw = $urandom_range(80, 1);
               sh = $urandom_range(80, 1);
               dw = $urandom_range(100, 1);
               dh = $urandom_range(100, 1);
               px = int'($urandom_range(570)) - 100;
               py = int'($urandom_range(410)) - 100;
            end
         endcase
         cfg[CSR_SPRITE_WIDTH]  = CSR_DATA_W'(sw);
         cfg[CSR_SPRITE_HEIGHT] = CSR_DATA_W'(sh);
         cfg[CSR_DEST_WIDTH]    = CSR_DATA_W'(dw);
         cfg[CSR_DEST_HEIGHT]   = CSR_DATA_W'(dh);
         cfg[CSR_POS_X]         = CSR_DATA_W'(px);
         cfg[CSR_POS_Y]         = CSR_DATA_W'(py);
         cfg[CSR_KEY_COLOR]     = CSR_DATA_W'(kc);
         for (int r = 0; r < NUM_CSR; r++) write_csr(CSR_INDEX_W'(r), cfg[r]);

         steady = (ph == STEADY_PHASE);   // one whole phase without idles
         span   = int'(spr_w) * int'(spr_h);
         if (span == 0 || span > STORE_DEPTH) span = STORE_DEPTH;

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == HOLD_PHASE && n == 20) hold_requests++;
            if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
               // sender stops until the block has returned everything
               req_valid <= 1'b0;
               wait (pending_blits.size() == 0);
               @(posedge clock);
            end
            if ($urandom_range(99) < 30) begin
               idx = ($urandom_range(9) != 0) ? $urandom_range(span - 1)
                                              : $urandom_range(STORE_DEPTH - 1);
               send_word(load_word(idx), 1'b0, NO_WRITE);
            end else begin
               noise = {$urandom, $urandom};
               w     = noise[$bits(req_type)-1:0];
               w.cmd = CMD_DRAW;
               w.dx  = ($urandom_range(99) < 85) ? DEST_DIM_W'($urandom_range(dst_w - 1))
                                                 : DEST_DIM_W'($urandom);
               w.dy  = ($urandom_range(99) < 85) ? DEST_DIM_W'($urandom_range(dst_h - 1))
                                                 : DEST_DIM_W'($urandom);
               // never read a pixel that was not loaded: load it first
               if (source_of(w.dx, w.dy, src) && !loaded[src])
                  send_word(load_word(src), 1'b0, NO_WRITE);
               send_word(w, 1'b0, NO_WRITE);
            end
         end
      end

      req_valid <= 1'b0;
      wait (pending_blits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin
      #(LIMIT_CYCLES * 2 * CLK_HALF);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/ssbck_pkg.sv
hdl/ssbck_div.sv
hdl/scaled_sprite_blit_color_key_unit.sv
sim/tb.sv
